### rtl/core/rsms_pkg.sv
// Shared types, microcode encoding and control program of the rotated sorted minimum search.
package rsms_pkg;

   localparam int MAX_ELEMENTS_DEF = 1024;
   localparam int DATA_W = 32;
   localparam int STEP_W = 3;

   // Program steps.
   localparam logic [STEP_W-1:0] STEP_CHECK     = 3'd0;
   localparam logic [STEP_W-1:0] STEP_READ_LOW  = 3'd1;
   localparam logic [STEP_W-1:0] STEP_TEST_LOW  = 3'd2;
   localparam logic [STEP_W-1:0] STEP_NARROW    = 3'd3;
   localparam logic [STEP_W-1:0] STEP_FETCH_MIN = 3'd4;
   localparam logic [STEP_W-1:0] STEP_EMIT      = 3'd5;

   // Read address selects.
   localparam logic [1:0] RD_LOW  = 2'd0;
   localparam logic [1:0] RD_HIGH = 2'd1;
   localparam logic [1:0] RD_MID  = 2'd2;

   // Jump conditions.
   localparam logic [1:0] COND_NONE       = 2'd0;
   localparam logic [1:0] COND_ALWAYS     = 2'd1;
   localparam logic [1:0] COND_RANGE_DONE = 2'd2;
   localparam logic [1:0] COND_LOW_LESS   = 2'd3;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     last;
   } req_word_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] min_value;
      logic                     overflow;
   } rsp_word_type;

   typedef struct packed {
      logic              rd_en;
      logic [1:0]        rd_sel;
      logic              cap_high;
      logic              update;
      logic              emit;
      logic              finish;
      logic [1:0]        cond;
      logic [STEP_W-1:0] target;
   } ctrl_word_type;

   typedef struct packed {
      logic range_done;
      logic low_less;
   } flags_type;

   function automatic ctrl_word_type ucode(input logic [STEP_W-1:0] step);
      ctrl_word_type cw;
      cw = '0;
      unique case (step)
         STEP_CHECK: begin
            cw.rd_en  = 1'b1;
            cw.rd_sel = RD_HIGH;
            cw.cond   = COND_RANGE_DONE;
            cw.target = STEP_FETCH_MIN;
         end
         STEP_READ_LOW: begin
            cw.rd_en    = 1'b1;
            cw.rd_sel   = RD_LOW;
            cw.cap_high = 1'b1;
         end
         STEP_TEST_LOW: begin
            cw.rd_en  = 1'b1;
            cw.rd_sel = RD_MID;
            cw.cond   = COND_LOW_LESS;
            cw.target = STEP_FETCH_MIN;
         end
         STEP_NARROW: begin
            cw.update = 1'b1;
            cw.cond   = COND_ALWAYS;
            cw.target = STEP_CHECK;
         end
         STEP_FETCH_MIN: begin
            cw.rd_en  = 1'b1;
            cw.rd_sel = RD_LOW;
         end
         STEP_EMIT: begin
            cw.emit   = 1'b1;
            cw.finish = 1'b1;
         end
         default: begin
            cw.finish = 1'b1;
         end
      endcase
      return cw;
   endfunction

endpackage

### rtl/core/rsms_sequencer.sv
// Step counter and microcode lookup that drive the search datapath.
module rsms_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   launch,
   input  rsms_pkg::flags_type     flags,
   output rsms_pkg::ctrl_word_type ctrl,
   output logic                   busy
);
   import rsms_pkg::*;

   logic              active_ff, active_in;
   logic [STEP_W-1:0] step_ff, step_in;
   ctrl_word_type     cw;
   logic              taken;

   always_comb begin
      cw = ucode(step_ff);
      unique case (cw.cond)
         COND_NONE:       taken = 1'b0;
         COND_ALWAYS:     taken = 1'b1;
         COND_RANGE_DONE: taken = flags.range_done;
         COND_LOW_LESS:   taken = flags.low_less;
         default:         taken = 1'b0;
      endcase

      active_in = active_ff;
      step_in   = step_ff;
      if (active_ff) begin
         if (cw.finish) begin
            active_in = 1'b0;
         end
         step_in = taken ? cw.target : step_ff + 1'b1;
      end else if (launch) begin
         active_in = 1'b1;
         step_in   = STEP_CHECK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         step_ff   <= STEP_CHECK;
      end else begin
         active_ff <= active_in;
         step_ff   <= step_in;
      end
   end

   assign ctrl = active_ff ? cw : '0;
   assign busy = active_ff;

endmodule

### rtl/core/rsms_datapath.sv
// Element buffer, search bounds, compare logic and result register.
module rsms_datapath #(
   parameter int MAX_ELEMENTS = rsms_pkg::MAX_ELEMENTS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  rsms_pkg::req_word_type  req_word,
   input  rsms_pkg::ctrl_word_type ctrl,
   output rsms_pkg::flags_type     flags,
   output logic                    launch,
   output logic                    rsp_strobe,
   output rsms_pkg::rsp_word_type  rsp_word
);
   import rsms_pkg::*;

   localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

   logic signed [DATA_W-1:0] mem [MAX_ELEMENTS];
   logic signed [DATA_W-1:0] rdata_ff;
   logic signed [DATA_W-1:0] high_val_ff;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             dropped_ff, dropped_in;
   logic [IDX_W-1:0] low_ff, low_in;
   logic [IDX_W-1:0] high_ff, high_in;
   logic             strobe_ff;
   rsp_word_type     rsp_ff;

   logic             has_room;
   logic             wr_en;
   logic [IDX_W-1:0] mid;
   logic [IDX_W-1:0] rd_addr;

   assign has_room = count_ff < CNT_W'(MAX_ELEMENTS);
   assign wr_en    = accept && has_room;
   assign launch   = accept && req_word.last;
   assign mid      = low_ff + ((high_ff - low_ff) >> 1);

   always_comb begin
      case (ctrl.rd_sel)
         RD_HIGH: rd_addr = high_ff;
         RD_MID:  rd_addr = mid;
         default: rd_addr = low_ff;
      endcase
   end

   assign flags.range_done = !(low_ff < high_ff);
   assign flags.low_less   = rdata_ff < high_val_ff;

   always_comb begin
      count_in   = count_ff;
      dropped_in = dropped_ff;
      low_in     = low_ff;
      high_in    = high_ff;
      if (accept) begin
         if (has_room) begin
            count_in = count_ff + 1'b1;
         end else begin
            dropped_in = 1'b1;
         end
         if (req_word.last) begin
            low_in  = '0;
            // Top index of the held elements, including this word if it fit.
            high_in = has_room ? count_ff[IDX_W-1:0] : IDX_W'(MAX_ELEMENTS - 1);
         end
      end
      if (ctrl.update) begin
         if (rdata_ff < high_val_ff) begin
            high_in = mid;
         end else if (rdata_ff > high_val_ff) begin
            low_in = mid + 1'b1;
         end else begin
            high_in = high_ff - 1'b1;
         end
      end
      if (ctrl.emit) begin
         count_in   = '0;
         dropped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         dropped_ff <= 1'b0;
         low_ff     <= '0;
         high_ff    <= '0;
         strobe_ff  <= 1'b0;
      end else begin
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
         low_ff     <= low_in;
         high_ff    <= high_in;
         strobe_ff  <= ctrl.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[IDX_W-1:0]] <= req_word.value;
      end
      if (ctrl.rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
      if (ctrl.cap_high) begin
         high_val_ff <= rdata_ff;
      end
      if (ctrl.emit) begin
         rsp_ff.min_value <= rdata_ff;
         rsp_ff.overflow  <= dropped_ff;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_word   = rsp_ff;

endmodule

### rtl/core/rotated_sorted_min_search.sv
// Top level of the rotated sorted array minimum search.
// Array words are taken one per cycle while busy is low and stored in an on-chip buffer of
// MAX_ELEMENTS entries; words beyond that depth are dropped and the result reports overflow.
// The word with last set starts a search run by a small microcoded sequencer over the single
// buffer read port: each narrowing step reads the high word, reads the low word, reads the
// middle word and updates the bounds. A search that ends because the low and high indexes
// meet finishes with a range check, a fetch of the low word and the result; one that ends
// because the low word is below the high word finishes with the range check, both reads, the
// fetch and the result. Duplicates can force the bounds to narrow one element at a time.
// The result appears for exactly one cycle with rsp_strobe, and a new array word may be
// offered in that same cycle; rsp_word keeps the result until the next one.
module rotated_sorted_min_search #(
   parameter int MAX_ELEMENTS = rsms_pkg::MAX_ELEMENTS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  rsms_pkg::req_word_type req_word,
   output logic                   busy,
   output logic                   rsp_strobe,
   output rsms_pkg::rsp_word_type rsp_word
);
   import rsms_pkg::*;

   ctrl_word_type ctrl;
   flags_type     flags;
   logic          launch;
   logic          accept;

   assign accept = start && !busy;

   rsms_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .launch (launch),
      .flags  (flags),
      .ctrl   (ctrl),
      .busy   (busy)
   );

   rsms_datapath #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_word   (req_word),
      .ctrl       (ctrl),
      .flags      (flags),
      .launch     (launch),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

endmodule

### tb/sv/tb.sv
// Self-checking testbench for the rotated sorted array minimum search block.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rsms_pkg::*;

   localparam int DEPTH = MAX_ELEMENTS_DEF;
   localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
   localparam int DIRECTED_LEN = 24;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     last;
      logic                     typed;
      rsp_word_type             want;
   } directed_row_type;

   // Single words, rotations, duplicates, unsorted input and extreme values. A typed result
   // is given only where it is obvious; other arrays are checked against the search below.
   localparam directed_row_type DIRECTED_ROWS [DIRECTED_LEN] = '{
      '{WORD_MIN, 1'b1, 1'b1, '{WORD_MIN, 1'b0}},
      '{WORD_MAX, 1'b1, 1'b1, '{WORD_MAX, 1'b0}},
      '{-32'sd1, 1'b1, 1'b1, '{-32'sd1, 1'b0}},
      '{32'sd0, 1'b1, 1'b1, '{32'sd0, 1'b0}},
      '{32'sd3, 1'b0, 1'b0, '{32'sd0, 1'b0}},
      '{32'sd4, 1'b0, 1'b0, '{32'sd0, 1'b0}},
      '{32'sd5, 1'b0, 1'b0, '{32'sd0, 1'b0}},
      '{32'sd1, 1'b0, 1'b0, '{32'sd0, 1'b0}},
      '{32'sd2, 1'b1, 1'b0, '{32'sd0, 1'b0}},
      '{32'sd7, 1'b0, 1'b0, '{32'sd0, 1'b0}},
      '{32'sd7, 1'b0, 1'b0, '{32'sd0, 1'b0}},
      '{32'sd7, 1'b1, 1'b1, '{32'sd7, 1'b0}},
      '{32'sd1, 1'b0, 1'b0, '{32'sd0, 1'b0}},
      '{32'sd1, 1'b0, 1'b0, '{32'sd0, 1'b0}},
      '{32'sd0, 1'b0, 1'b0, '{32'sd0, 1'b0}},
      '{32'sd1, 1'b1, 1'b0, '{32'sd0, 1'b0}},
      '{32'sd5, 1'b0, 1'b0, '{32'sd0, 1'b0}},
      '{-32'sd3, 1'b0, 1'b0, '{32'sd0, 1'b0}},
      '{32'sd9, 1'b1, 1'b0, '{32'sd0, 1'b0}},
      '{WORD_MAX, 1'b0, 1'b0, '{32'sd0, 1'b0}},
      '{WORD_MIN, 1'b0, 1'b0, '{32'sd0, 1'b0}},
      '{32'sd0, 1'b1, 1'b0, '{32'sd0, 1'b0}},
      '{WORD_MIN, 1'b0, 1'b0, '{32'sd0, 1'b0}},
      '{WORD_MAX, 1'b1, 1'b1, '{WORD_MIN, 1'b0}}
   };

   logic         clock;
   logic         reset;
   logic         start;
   req_word_type req_word;
   logic         busy;
   logic         rsp_strobe;
   rsp_word_type rsp_word;

   rotated_sorted_min_search u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_word   (req_word),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   // Predicted contents of the element buffer for the array being loaded.
   logic signed [DATA_W-1:0] held_values [DEPTH];
   int                       held_count = 0;
   logic                     held_dropped = 1'b0;

   rsp_word_type             expected_minimums [$];
   logic signed [DATA_W-1:0] array_words [$];
   int                       mismatch_count = 0;
   int                       burst_left = 0;
   int                       words_sent = 0;
   int                       arrays_sent = 0;
   int                       overrun_arrays = 0;
   int                       longest_array = 0;

   initial begin
      clock = 1'b0;
   end

   always begin
      #6 clock = ~clock;
   end

   function automatic rsp_word_type search_minimum();
      int unsigned  lo;
      int unsigned  hi;
      int unsigned  mid;
      logic         settled;
      rsp_word_type result;
      lo = 0;
      hi = held_count - 1;
      settled = 1'b0;
      while (lo < hi && !settled) begin
         if (held_values[lo] < held_values[hi]) begin
            settled = 1'b1;
         end else begin
            mid = lo + (hi - lo) / 2;
            if (held_values[mid] < held_values[hi]) begin
               hi = mid;
            end else if (held_values[mid] > held_values[hi]) begin
               lo = mid + 1;
            end else begin
               hi = hi - 1;
            end
         end
      end
      result.min_value = held_values[lo];
      result.overflow = held_dropped;
      return result;
   endfunction

   // Takes one accepted word into the predicted buffer; returns 1 when it closes an array.
   function automatic bit store_word(input logic signed [DATA_W-1:0] value, input logic last,
                                     output rsp_word_type result);
      result = '0;
      if (held_count < DEPTH) begin
         held_values[held_count] = value;
         held_count++;
      end else begin
         held_dropped = 1'b1;
      end
      if (!last) begin
         return 1'b0;
      end
      result = search_minimum();
      held_count = 0;
      held_dropped = 1'b0;
      return 1'b1;
   endfunction

   // Builds a rotated ascending array; a step repeats 1 in 3, or always for step_limit 0.
   function automatic void fill_rotated(input int n, input int unsigned step_limit);
      logic signed [DATA_W-1:0] ascending [$];
      longint unsigned          span;
      longint unsigned          offset;
      longint                   level;
      int                       shift;
      span = longint'(n) * step_limit;
      offset = {$urandom, $urandom} % (64'd4294967296 - span);
      level = longint'(offset) - 64'sd2147483648;
      array_words.delete();
      for (int i = 0; i < n; i++) begin
         ascending.push_back(level[DATA_W-1:0]);
         if (step_limit > 0 && $urandom_range(0, 2) != 0) begin
            level = level + $urandom_range(1, step_limit);
         end
      end
      shift = $urandom_range(0, n - 1);
      for (int i = 0; i < n; i++) begin
         array_words.push_back(ascending[(i + shift) % n]);
      end
   endfunction

   // Builds an unsorted array, either full range or from a narrow band full of repeats.
   function automatic void fill_noise(input int n);
      logic                     narrow;
      logic signed [DATA_W-1:0] w;
      narrow = 1'($urandom_range(0, 1));
      array_words.delete();
      for (int i = 0; i < n; i++) begin
         w = $urandom;
         if (narrow) begin
            w = $urandom_range(0, 4);
            w = w - 32'sd2;
         end
         array_words.push_back(w);
      end
   endfunction

   task automatic send_word(input logic signed [DATA_W-1:0] value, input logic last,
                            input logic typed, input rsp_word_type typed_want);
      rsp_word_type found;
      req_word_type w;
      int           gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      w.value = value;
      w.last = last;
      start <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
      burst_left--;
      words_sent++;
      if (store_word(value, last, found)) begin
         expected_minimums.push_back(typed ? typed_want : found);
         arrays_sent++;
      end
   endtask

   task automatic send_array();
      int n;
      n = array_words.size();
      for (int i = 0; i < n; i++) begin
         send_word(array_words[i], i == n - 1, 1'b0, '0);
      end
      if (n > DEPTH) begin
         overrun_arrays++;
      end
      if (n > longest_array) begin
         longest_array = n;
      end
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_strobe) begin
         if (expected_minimums.size() == 0) begin
            $error("unexpected result: min_value %0d overflow %0b",
                   rsp_word.min_value, rsp_word.overflow);
            mismatch_count++;
         end else begin
            want = expected_minimums.pop_front();
            if (rsp_word.min_value !== want.min_value) begin
               $error("min_value: expected %0d, got %0d", want.min_value, rsp_word.min_value);
               mismatch_count++;
            end
            if (rsp_word.overflow !== want.overflow) begin
               $error("overflow: expected %0b, got %0b", want.overflow, rsp_word.overflow);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      #3ms;
      $display("rotated_sorted_min_search verification failed");
      $finish;
   end

   initial begin
      int          small_words;
      int          n;
      int          kind;
      int          waited;
      int unsigned step_choices [4];
      step_choices = '{1, 3, 1000, 4000000};
      reset = 1'b1;
      start = 1'b0;
      req_word = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_LEN; i++) begin
         send_word(DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].last, DIRECTED_ROWS[i].typed,
                   DIRECTED_ROWS[i].want);
      end

      small_words = 0;
      while (small_words < 426) begin
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
         kind = $urandom_range(0, 9);
         if (kind < 6) begin
            fill_rotated(n, step_choices[$urandom_range(0, 3)]);
         end else if (kind < 7) begin
            fill_rotated(n, 0);
         end else begin
            fill_noise(n);
         end
         send_array();
         small_words += n;
      end
      start <= 1'b0;

      waited = 0;
      while (expected_minimums.size() != 0 && waited < 50000) begin
         @(posedge clock);
         waited++;
      end
      if (expected_minimums.size() != 0) begin
         $display("rotated_sorted_min_search verification failed");
         $finish;
      end else begin
         repeat (8) @(posedge clock);
         $display("Ran %0d arrays from %0d words, %0d of them past the buffer depth;",
                  arrays_sent, words_sent, overrun_arrays);
         $display("the longest array held %0d words.", longest_array);
         if (mismatch_count == 0) begin
            $display("rotated_sorted_min_search verification clean");
         end else begin
            $display("rotated_sorted_min_search verification failed");
         end
         $finish;
      end
   end

endmodule

### sim.f
rtl/core/rsms_pkg.sv
rtl/core/rsms_sequencer.sv
rtl/core/rsms_datapath.sv
rtl/core/rotated_sorted_min_search.sv
tb/sv/tb.sv
